>>> rtl/compacting_array_list_engine_unit_macros.svh
// assertion helpers for the list engine, sampled on clk and held off while rst_n is low
`ifndef COMPACTING_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH
`define COMPACTING_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define CALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CALE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cale_pkg.sv
package cale_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int DATA_W   = 32;
  localparam int OPC_W    = 3;
  localparam int POS_W    = 6;
  localparam int ST_W     = 2;
  localparam int RIDX_W   = 6;
  localparam int ECNT_W   = 7;

  localparam int IN_W     = 48;
  localparam int OUT_W    = 48;
  localparam int OUT_PAD  = OUT_W - (ST_W + DATA_W + RIDX_W + ECNT_W);

  localparam logic [OPC_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE_POS = 3'd1;
  localparam logic [OPC_W-1:0] OP_REMOVE_VAL = 3'd2;
  localparam logic [OPC_W-1:0] OP_FIND       = 3'd3;
  localparam logic [OPC_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OPC_W-1:0] OP_READ       = 3'd5;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_READ,
    S_FIN
  } state_t;

endpackage

>>> rtl/cale_ram.sv
module cale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/compacting_array_list_engine_unit.sv
// Packed list of up to CAPACITY signed 32-bit values in a single-port-read RAM. One request is
// handled at a time and gives one response; the response register lets the next request in
// while the previous response waits. Append, clear, unknown opcodes and rejected requests go
// straight from idle to the finish state, and read passes through a read state first. Find and
// remove-value compare one stored entry per cycle from entry 0 up to the first match; a removal
// then moves each later entry down one place per cycle. This pace is set by the one read port
// of the entry RAM.
`include "compacting_array_list_engine_unit_macros.svh"

module compacting_array_list_engine_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // opcode[2:0], data_value[34:3], position[40:35], zero fill
  input  logic [cale_pkg::IN_W-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[1:0], result_value[33:2], result_index[39:34], element_count[46:40], zero fill
  output logic [cale_pkg::OUT_W-1:0] out_tdata
);

  localparam int IW = cale_pkg::IDX_W;

  cale_pkg::state_t state_r, state_nxt;
  cale_pkg::count_t count_r, count_nxt;
  cale_pkg::idx_t   ptr_r, ptr_nxt;
  cale_pkg::idx_t   ri_r, ri_nxt;
  logic [cale_pkg::OPC_W-1:0]  op_r, op_nxt;
  logic [cale_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [cale_pkg::DATA_W-1:0] rv_r, rv_nxt;
  logic [cale_pkg::ST_W-1:0]   st_r, st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [cale_pkg::OUT_W-1:0]  out_data_r, out_data_nxt;

  logic [cale_pkg::OPC_W-1:0]  in_opcode;
  logic [cale_pkg::DATA_W-1:0] in_value;
  logic [cale_pkg::POS_W-1:0]  in_pos;
  logic                        accept;
  logic                        pos_ok, pos_p1_ok, full, cnt_zero, hit;
  logic                        ptr_p1_ok, ptr_p2_ok, out_free;
  logic [IW:0]                 ptr_p1, ptr_p2;

  logic                        mem_we;
  cale_pkg::idx_t              mem_waddr, mem_raddr;
  logic [cale_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  assign in_opcode = in_tdata[2:0];
  assign in_value  = in_tdata[34:3];
  assign in_pos    = in_tdata[40:35];

  // no request is taken while reset is held
  assign in_tready  = rst_n && (state_r == cale_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign pos_ok    = 32'(in_pos) < 32'(count_r);
  assign pos_p1_ok = (32'(in_pos) + 32'd1) < 32'(count_r);
  assign full      = 32'(count_r) >= 32'(cale_pkg::CAPACITY);
  assign cnt_zero  = (count_r == '0);
  assign ptr_p1    = {1'b0, ptr_r} + (IW+1)'(1);
  assign ptr_p2    = {1'b0, ptr_r} + (IW+1)'(2);
  assign ptr_p1_ok = 32'(ptr_p1) < 32'(count_r);
  assign ptr_p2_ok = 32'(ptr_p2) < 32'(count_r);
  assign hit       = (mem_rdata == val_r);

  cale_ram #(
    .WIDTH (cale_pkg::DATA_W),
    .DEPTH (cale_pkg::CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cale_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            cale_pkg::OP_REMOVE_POS: begin
              state_nxt = (pos_ok && pos_p1_ok) ? cale_pkg::S_SHIFT : cale_pkg::S_FIN;
            end
            cale_pkg::OP_REMOVE_VAL, cale_pkg::OP_FIND: begin
              state_nxt = cnt_zero ? cale_pkg::S_FIN : cale_pkg::S_SEARCH;
            end
            cale_pkg::OP_READ: begin
              state_nxt = pos_ok ? cale_pkg::S_READ : cale_pkg::S_FIN;
            end
            default: begin
              state_nxt = cale_pkg::S_FIN;
            end
          endcase
        end
      end
      cale_pkg::S_SEARCH: begin
        if (hit) begin
          state_nxt = (op_r == cale_pkg::OP_REMOVE_VAL && ptr_p1_ok) ?
                      cale_pkg::S_SHIFT : cale_pkg::S_FIN;
        end else if (!ptr_p1_ok) begin
          state_nxt = cale_pkg::S_FIN;
        end
      end
      cale_pkg::S_SHIFT: begin
        if (!ptr_p2_ok) begin
          state_nxt = cale_pkg::S_FIN;
        end
      end
      cale_pkg::S_READ: begin
        state_nxt = cale_pkg::S_FIN;
      end
      cale_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = cale_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cale_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = ptr_p1[IW-1:0];
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    st_nxt        = st_r;
    rv_nxt        = rv_r;
    ri_nxt        = ri_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      cale_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt  = in_opcode;
          val_nxt = in_value;
          st_nxt  = cale_pkg::ST_DONE;
          rv_nxt  = '0;
          ri_nxt  = '0;
          ptr_nxt = IW'(in_pos);
          unique case (in_opcode)
            cale_pkg::OP_APPEND: begin
              if (full) begin
                st_nxt = cale_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[IW-1:0];
                mem_wdata = in_value;
                count_nxt = count_r + cale_pkg::CNT_W'(1);
              end
            end
            cale_pkg::OP_REMOVE_POS: begin
              mem_raddr = IW'(in_pos) + IW'(1);
              if (!pos_ok) begin
                st_nxt = cale_pkg::ST_INVALID;
              end else if (!pos_p1_ok) begin
                // last entry goes, nothing to move down
                count_nxt = count_r - cale_pkg::CNT_W'(1);
              end
            end
            cale_pkg::OP_REMOVE_VAL, cale_pkg::OP_FIND: begin
              mem_raddr = '0;
              ptr_nxt   = '0;
              if (cnt_zero) begin
                st_nxt = cale_pkg::ST_INVALID;
              end
            end
            cale_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            cale_pkg::OP_READ: begin
              mem_raddr = IW'(in_pos);
              if (!pos_ok) begin
                st_nxt = cale_pkg::ST_INVALID;
              end
            end
            default: begin
              st_nxt = cale_pkg::ST_INVALID;
            end
          endcase
        end
      end
      cale_pkg::S_SEARCH: begin
        // read data belongs to ptr_r, the next entry is already being fetched
        if (hit) begin
          ri_nxt = ptr_r;
          if (op_r == cale_pkg::OP_REMOVE_VAL && !ptr_p1_ok) begin
            count_nxt = count_r - cale_pkg::CNT_W'(1);
          end
        end else if (!ptr_p1_ok) begin
          st_nxt = cale_pkg::ST_INVALID;
        end else begin
          ptr_nxt = ptr_p1[IW-1:0];
        end
      end
      cale_pkg::S_SHIFT: begin
        // entry ptr+1 arrives and lands at ptr while ptr+2 is fetched
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = mem_rdata;
        mem_raddr = ptr_p2[IW-1:0];
        if (ptr_p2_ok) begin
          ptr_nxt = ptr_p1[IW-1:0];
        end else begin
          count_nxt = count_r - cale_pkg::CNT_W'(1);
        end
      end
      cale_pkg::S_READ: begin
        rv_nxt = mem_rdata;
      end
      cale_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{cale_pkg::OUT_PAD{1'b0}}, cale_pkg::ECNT_W'(count_r),
                           cale_pkg::RIDX_W'(ri_r), rv_r, st_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cale_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    st_r       <= st_nxt;
    rv_r       <= rv_nxt;
    ri_r       <= ri_nxt;
    out_data_r <= out_data_nxt;
  end

  `CALE_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_r) <= 32'(cale_pkg::CAPACITY), "count too big")
  `CALE_ASSERT_IMP(a_shift_range, state_r == cale_pkg::S_SHIFT, ptr_p1_ok, "shift past end")
  `CALE_ASSERT_IMP(a_write_state, mem_we, accept || state_r == cale_pkg::S_SHIFT, "stray write")
  `CALE_ASSERT_NXT(a_fin_load, state_r == cale_pkg::S_FIN && out_free, out_valid_r, "no response")

endmodule
